/* rtl/core/kl_pkg.sv */
// kl_pkg: shared widths, token kind codes and payload types for the keyword lexer.
// Depends on nothing; every rtl/core module imports it.
`timescale 1ns / 1ps

package kl_pkg;

   // Field widths
   localparam int POSITION_BITS = 16;
   localparam int LENGTH_BITS   = 8;
   localparam int KIND_BITS     = 3;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   // Token kind codes
   localparam logic [KIND_BITS-1:0] KIND_PLUS   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_SEMI   = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_VAR    = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_CONST  = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_IDENT  = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER = 3'd6;

   // Token queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // One source byte
   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_source;
   } req_type;

   // One token
   typedef struct packed {
      logic [KIND_BITS-1:0]     token_kind;
      logic [POSITION_BITS-1:0] start_offset;
      logic [LENGTH_BITS-1:0]   lexeme_length;
      logic                     length_saturated;
      logic                     last_of_run;
   } rsp_type;

   // Everything one byte produces: one or two tokens
   typedef struct packed {
      logic    two_tokens;
      rsp_type tok0;
      rsp_type tok1;
   } pair_type;

endpackage

/* rtl/core/kl_front.sv */
// kl_front: takes one source byte per cycle while the queue is not full, tracks the
// pending run and keyword prefix, and pushes the byte's one or two tokens. Uses kl_pkg.
`timescale 1ns / 1ps

module kl_front import kl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_data,
   input  logic     q_full,
   output logic     q_push,
   output pair_type q_data
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER
   } mode_type;

   // Keyword prefix tracker codes
   localparam logic [2:0] PROG_NONE = 3'd0;
   localparam logic [2:0] PROG_V    = 3'd1;
   localparam logic [2:0] PROG_VA   = 3'd2;
   localparam logic [2:0] PROG_VAR  = 3'd3;
   localparam logic [2:0] PROG_C    = 3'd4;
   localparam logic [2:0] PROG_CO   = 3'd5;
   localparam logic [2:0] PROG_CON  = 3'd6;
   localparam logic [2:0] PROG_CONS = 3'd7;

   // Character codes
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_V     = 8'h76;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_T     = 8'h74;

   localparam logic [LENGTH_BITS-1:0] LEN_ONE   = LENGTH_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] LEN_THREE = LENGTH_BITS'(3);
   localparam logic [LENGTH_BITS-1:0] LEN_FOUR  = LENGTH_BITS'(4);
   localparam logic [LENGTH_BITS-1:0] LEN_FIVE  = LENGTH_BITS'(5);

   // Kind of a finished run
   function automatic logic [KIND_BITS-1:0] run_kind(
      input mode_type               m,
      input logic                   ovf,
      input logic [2:0]             prog,
      input logic [LENGTH_BITS-1:0] len
   );
      logic [KIND_BITS-1:0] k;
      if (m == MODE_NUMBER)
         k = KIND_NUMBER;
      else if (!ovf && prog == PROG_VAR && len == LEN_THREE)
         k = KIND_VAR;
      else if (!ovf && prog == PROG_CONS && len == LEN_FIVE)
         k = KIND_CONST;
      else
         k = KIND_IDENT;
      return k;
   endfunction

   // Keyword prefix step on an identifier continuation
   function automatic logic [2:0] next_prog(
      input logic [2:0]             p,
      input logic [7:0]             c,
      input logic [LENGTH_BITS-1:0] len
   );
      logic [2:0] n;
      n = PROG_NONE;
      unique case (p)
         PROG_V:    if (c == CH_A) n = PROG_VA;
         PROG_VA:   if (c == CH_R) n = PROG_VAR;
         PROG_C:    if (c == CH_O) n = PROG_CO;
         PROG_CO:   if (c == CH_N) n = PROG_CON;
         PROG_CON:  if (c == CH_S) n = PROG_CONS;
         PROG_CONS: if (c == CH_T && len == LEN_FOUR) n = PROG_CONS;
         default:   n = PROG_NONE;
      endcase
      return n;
   endfunction

   mode_type                 mode_ff,  mode_in;
   logic [POSITION_BITS-1:0] pos_ff,   pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0]   len_ff,   len_in;
   logic [2:0]               prog_ff,  prog_in;
   logic                     ovf_ff,   ovf_in;

   logic       accept;
   logic [7:0] c;
   logic       eos, letter, digit, under, is_sym;
   logic       cont, close_run, sym_emit, flush;
   mode_type   mode_run;
   rsp_type    closed_tok, sym_tok, flush_tok, second_tok;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign c      = req_data.char_byte;
   assign eos    = req_data.end_of_source;

   // Character classes
   assign letter = (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
   assign digit  = (c >= CH_0 && c <= CH_9);
   assign under  = (c == CH_UNDER);
   assign is_sym = (c == CH_PLUS) || (c == CH_SEMI) || (c == CH_EQUAL);

   // Run tracking and token building
   always_comb begin
      cont = (mode_ff == MODE_IDENT && (letter || under)) ||
             (mode_ff == MODE_NUMBER && digit);
      close_run = !cont && (mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER);
      sym_emit  = !cont && is_sym;

      mode_run = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      prog_in  = prog_ff;
      ovf_in   = ovf_ff;
      if (cont) begin
         // extend, saturating at the length maximum
         len_in = (len_ff == LEN_MAX) ? len_ff : len_ff + LEN_ONE;
         ovf_in = ovf_ff || (len_ff == LEN_MAX);
         if (mode_ff == MODE_IDENT)
            prog_in = next_prog(prog_ff, c, len_ff);
      end else if (letter) begin
         mode_run = MODE_IDENT;
         start_in = pos_ff;
         len_in   = LEN_ONE;
         ovf_in   = 1'b0;
         prog_in  = (c == CH_V) ? PROG_V : ((c == CH_C) ? PROG_C : PROG_NONE);
      end else if (digit) begin
         mode_run = MODE_NUMBER;
         start_in = pos_ff;
         len_in   = LEN_ONE;
         ovf_in   = 1'b0;
         prog_in  = PROG_NONE;
      end else begin
         mode_run = MODE_IDLE;
      end

      flush   = eos && (mode_run == MODE_IDENT || mode_run == MODE_NUMBER);
      mode_in = eos ? MODE_IDLE : mode_run;
      pos_in  = eos ? '0 : pos_ff + POSITION_BITS'(1);

      closed_tok.token_kind       = run_kind(mode_ff, ovf_ff, prog_ff, len_ff);
      closed_tok.start_offset     = start_ff;
      closed_tok.lexeme_length    = len_ff;
      closed_tok.length_saturated = ovf_ff;
      closed_tok.last_of_run      = 1'b0;

      case (c)
         CH_PLUS: sym_tok.token_kind = KIND_PLUS;
         CH_SEMI: sym_tok.token_kind = KIND_SEMI;
         default: sym_tok.token_kind = KIND_EQUAL;
      endcase
      sym_tok.start_offset     = pos_ff;
      sym_tok.lexeme_length    = LEN_ONE;
      sym_tok.length_saturated = 1'b0;
      sym_tok.last_of_run      = 1'b1;

      flush_tok.token_kind       = run_kind(mode_run, ovf_in, prog_in, len_in);
      flush_tok.start_offset     = start_in;
      flush_tok.lexeme_length    = len_in;
      flush_tok.length_saturated = ovf_in;
      flush_tok.last_of_run      = 1'b1;

      // symbol and flush never occur together: a symbol leaves no run open
      second_tok = sym_emit ? sym_tok : flush_tok;

      if (close_run) begin
         q_data.two_tokens           = sym_emit || flush;
         q_data.tok0                 = closed_tok;
         q_data.tok0.last_of_run     = !(sym_emit || flush);
         q_data.tok1                 = second_tok;
      end else begin
         q_data.two_tokens = 1'b0;
         q_data.tok0       = second_tok;
         q_data.tok1       = second_tok;
      end
      q_push = accept && (close_run || sym_emit || flush);
   end

   // Lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         prog_ff  <= PROG_NONE;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         prog_ff  <= prog_in;
         ovf_ff   <= ovf_in;
      end
   end

   // An open run always has at least one character
   a_open_run_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDLE) |-> (len_ff != '0))
      else $error("open run with zero length");

   // The end of a source restarts offsets at zero
   a_eos_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && eos) |=> (pos_ff == '0 && mode_ff == MODE_IDLE))
      else $error("end of source did not restart the lexer");

endmodule

/* rtl/core/kl_queue.sv */
// kl_queue: short FIFO of token pairs between the lexer front and the output back.
// Uses kl_pkg for the depth and the pair type.
`timescale 1ns / 1ps

module kl_queue import kl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pair_type push_data,
   output logic     full,
   input  logic     pop,
   output pair_type head_data,
   output logic     empty
);

   pair_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff,  count_in;
   logic                      wr, rd;

   assign full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign wr        = push && !full;
   assign rd        = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr && !rd)
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      else if (rd && !wr)
         count_in = count_ff - QUEUE_CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (wr)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   // The front must never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("token pair pushed into full queue");

endmodule

/* rtl/core/kl_back.sv */
// kl_back: output stage; takes token pairs from the queue and hands out one token
// per pop. Uses kl_pkg.
`timescale 1ns / 1ps

module kl_back import kl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  pair_type q_data,
   output logic     q_pop,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_data
);

   logic     valid_ff, valid_in;
   logic     sub_ff,   sub_in;
   pair_type entry_ff;
   logic     take, advance, need_slot;

   assign take      = pop && valid_ff;
   assign advance   = take && entry_ff.two_tokens && !sub_ff;
   assign need_slot = !valid_ff || (take && !advance);
   assign q_pop     = need_slot && !q_empty;
   assign empty     = !valid_ff;
   assign rsp_data  = sub_ff ? entry_ff.tok1 : entry_ff.tok0;

   // Slot control
   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      if (advance) begin
         sub_in = 1'b1;
      end else if (need_slot) begin
         valid_in = !q_empty;
         sub_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   // Pair payload, no reset
   always_ff @(posedge clock) begin
      if (q_pop)
         entry_ff <= q_data;
   end

   // Second token is only shown for pairs that carry one
   a_sub_two: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (valid_ff && entry_ff.two_tokens))
      else $error("second token shown for single-token pair");

   // A waiting pair reaches an empty output stage in the next cycle
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (!valid_ff && !q_empty) |=> valid_ff)
      else $error("output stage did not refill");

endmodule

/* rtl/core/keyword_lexer_unit.sv */
// keyword_lexer_unit: top level of the keyword lexer; front, token queue and back.
// Depends on kl_pkg, kl_front, kl_queue and kl_back.
//
//   channel   ports                         moves
//   request   push, full, req_data          one source byte, end-of-source mark
//   response  empty, pop, rsp_data          one token: kind, offset, length, flags
//
// One source byte is taken per clock as long as the token queue has room.
// A byte that gives two tokens (run end plus symbol, or run end plus flush)
// has them handed out one per pop by the single output stage. A token passes
// through the token queue and the output stage register before it reaches
// the response ports.
// Reset is synchronous and clears the lexer state, the queue and the output
// stage; offsets restart at zero after reset and after each end-of-source byte.
// full rises when four token pairs wait; pop stalls never block the front
// until then.
`timescale 1ns / 1ps

module keyword_lexer_unit import kl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic     q_push, q_full, q_pop, q_empty;
   pair_type q_wdata, q_rdata;

   kl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   kl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_rdata),
      .empty     (q_empty)
   );

   kl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rdata),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

/* bench/tb_keyword_lexer_unit.sv */
// tb_keyword_lexer_unit: self-checking bench for the keyword lexer; predicts tokens per byte
// and checks every popped token in order. Depends on kl_pkg and keyword_lexer_unit.
`timescale 1ns / 1ps

module tb_keyword_lexer_unit;
   import kl_pkg::*;

   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_SEMI  = ";";
   localparam logic [7:0] CH_EQUAL = "=";
   localparam logic [7:0] CH_UNDER = "_";
   localparam logic [7:0] CH_SPACE = " ";

   localparam int RANDOM_BYTES = 400;

   typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_NUMBER} run_mode_type;
   typedef enum logic [2:0] {
      KW_NONE, KW_V, KW_VA, KW_VAR, KW_C, KW_CO, KW_CON, KW_CONS
   } keyword_state_type;

   // One queued source byte, or a marker that holds the sender until all tokens are out
   typedef struct {
      req_type req;
      bit      rush;
      bit      drain;
   } source_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   source_entry_type source_text[$];
   rsp_type          tokens_due[$];
   int               mismatches = 0;
   bit               req_taken = 1'b0;

   // Lexer state as predicted
   run_mode_type             lex_mode;
   keyword_state_type        kw_state;
   logic [POSITION_BITS-1:0] byte_pos;
   logic [POSITION_BITS-1:0] run_start;
   logic [LENGTH_BITS-1:0]   run_len;
   logic                     run_ovf;

   keyword_lexer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Token prediction
   // ---------------------------------------------------------------
   function automatic rsp_type run_token();
      rsp_type tok;
      tok = '0;
      if (lex_mode == MODE_NUMBER)
         tok.token_kind = KIND_NUMBER;
      else if (!run_ovf && kw_state == KW_VAR && run_len == LENGTH_BITS'(3))
         tok.token_kind = KIND_VAR;
      else if (!run_ovf && kw_state == KW_CONS && run_len == LENGTH_BITS'(5))
         tok.token_kind = KIND_CONST;
      else
         tok.token_kind = KIND_IDENT;
      tok.start_offset     = run_start;
      tok.lexeme_length    = run_len;
      tok.length_saturated = run_ovf;
      return tok;
   endfunction

   function automatic rsp_type symbol_token(logic [KIND_BITS-1:0] kind,
                                            logic [POSITION_BITS-1:0] at);
      rsp_type tok;
      tok = '0;
      tok.token_kind    = kind;
      tok.start_offset  = at;
      tok.lexeme_length = LENGTH_BITS'(1);
      return tok;
   endfunction

   function automatic void grow_run();
      if (run_len == LEN_MAX)
         run_ovf = 1'b1;
      else
         run_len = run_len + LENGTH_BITS'(1);
   endfunction

   // Advance the lexer by one byte and queue the tokens it yields
   function automatic void lex_byte(req_type r);
      logic [7:0]               c;
      logic                     letter, digit, under;
      logic [POSITION_BITS-1:0] here;
      rsp_type                  made[$];
      c      = r.char_byte;
      here   = byte_pos;
      letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      digit  = (c >= "0" && c <= "9");
      under  = (c == CH_UNDER);

      if (lex_mode == MODE_IDENT && (letter || under)) begin
         // keyword tracking looks at the length before this byte
         case (kw_state)
            KW_V:    kw_state = (c == "a") ? KW_VA : KW_NONE;
            KW_VA:   kw_state = (c == "r") ? KW_VAR : KW_NONE;
            KW_C:    kw_state = (c == "o") ? KW_CO : KW_NONE;
            KW_CO:   kw_state = (c == "n") ? KW_CON : KW_NONE;
            KW_CON:  kw_state = (c == "s") ? KW_CONS : KW_NONE;
            KW_CONS: kw_state = (run_len == LENGTH_BITS'(4) && c == "t") ? KW_CONS : KW_NONE;
            default: kw_state = KW_NONE;
         endcase
         grow_run();
      end else if (lex_mode == MODE_NUMBER && digit) begin
         grow_run();
      end else begin
         if (lex_mode != MODE_IDLE) begin
            made.insert(made.size(), run_token());
            lex_mode = MODE_IDLE;
         end
         if (c == CH_PLUS)
            made.insert(made.size(), symbol_token(KIND_PLUS, here));
         else if (c == CH_SEMI)
            made.insert(made.size(), symbol_token(KIND_SEMI, here));
         else if (c == CH_EQUAL)
            made.insert(made.size(), symbol_token(KIND_EQUAL, here));
         else if (letter || digit) begin
            lex_mode  = letter ? MODE_IDENT : MODE_NUMBER;
            run_start = here;
            run_len   = LENGTH_BITS'(1);
            run_ovf   = 1'b0;
            kw_state  = (c == "v") ? KW_V : ((c == "c") ? KW_C : KW_NONE);
         end
      end

      // end of source flushes whatever run is still open
      if (r.end_of_source && lex_mode != MODE_IDLE) begin
         made.insert(made.size(), run_token());
         lex_mode = MODE_IDLE;
      end

      if (made.size() > 0)
         made[made.size()-1].last_of_run = 1'b1;
      foreach (made[i])
         tokens_due.insert(tokens_due.size(), made[i]);

      byte_pos = r.end_of_source ? '0 : here + POSITION_BITS'(1);
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Idle pattern: mostly short gaps, a few long ones
   // ---------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // ---------------------------------------------------------------
   // Source text construction
   // ---------------------------------------------------------------
   task automatic add_byte(input logic [7:0] c, input bit rush = 1'b0);
      source_entry_type e;
      e.req.char_byte     = c;
      e.req.end_of_source = 1'b0;
      e.rush              = rush;
      e.drain             = 1'b0;
      source_text.insert(source_text.size(), e);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endtask

   task automatic end_source();
      source_text[source_text.size()-1].req.end_of_source = 1'b1;
   endtask

   task automatic add_drain();
      source_entry_type e;
      e.req   = '0;
      e.rush  = 1'b0;
      e.drain = 1'b1;
      source_text.insert(source_text.size(), e);
   endtask

   function automatic logic [7:0] rand_letter();
      int unsigned r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'("a" + r) : 8'("A" + (r - 26));
   endfunction

   // Mostly well-formed statements with random content, some noise
   task automatic add_random_source();
      string       near_miss[10];
      int unsigned pieces;
      near_miss = '{"va", "vars", "cons", "constant", "Var", "CONST", "v_ar", "const_",
                    "c", "vx"};
      pieces = $urandom_range(1, 10);
      for (int p = 0; p < pieces; p++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               if ($urandom_range(0, 1))
                  add_text("var");
               else
                  add_text("const");
            end
            2:    add_text(near_miss[$urandom_range(0, 9)]);
            3, 4: begin
               add_byte(rand_letter());
               repeat ($urandom_range(0, 8))
                  add_byte(($urandom_range(0, 4) == 0) ? CH_UNDER : rand_letter());
            end
            5, 6: repeat ($urandom_range(1, 6)) add_byte(8'("0" + $urandom_range(0, 9)));
            7, 8: begin
               case ($urandom_range(0, 2))
                  0: add_byte(CH_PLUS);
                  1: add_byte(CH_SEMI);
                  default: add_byte(CH_EQUAL);
               endcase
            end
            default: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
         endcase
         // separator half of the time, so runs also butt against each other
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0: add_byte(CH_SPACE);
               1: add_byte(CH_UNDER);
               2: add_byte(8'h0A);
               default: add_byte(8'($urandom_range(0, 255)));
            endcase
         end
      end
      if ($urandom_range(0, 99) < 85)
         end_source();
   endtask

   // ---------------------------------------------------------------
   // Request driver: falling edge, fed from source_text
   // ---------------------------------------------------------------
   int unsigned send_gap = 0;
   int unsigned send_steady = 0;

   always @(negedge clock) begin : sender
      source_entry_type entry;
      bit               next_push;
      next_push = push;
      if (!reset && (!push || req_taken)) begin
         next_push = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (source_text.size() > 0) begin
            if (source_text[0].drain) begin
               if (tokens_due.size() == 0)
                  void'(source_text.pop_front());
            end else begin
               entry = source_text.pop_front();
               req_data <= entry.req;
               next_push = 1'b1;
               if (send_steady > 0)
                  send_steady--;
               else if ($urandom_range(0, 99) == 0)
                  send_steady = $urandom_range(30, 120);
               send_gap = (entry.rush || send_steady > 0) ? 0 : pick_gap();
            end
         end
      end
      push <= next_push;
   end

   // ---------------------------------------------------------------
   // Response pop driver: random stalls
   // ---------------------------------------------------------------
   int unsigned pop_stall = 0;
   int unsigned pop_steady = 0;

   always @(negedge clock) begin : receiver
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_stall > 0) begin
         pop_stall--;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
         if (pop_steady > 0)
            pop_steady--;
         else if ($urandom_range(0, 99) == 0)
            pop_steady = $urandom_range(30, 120);
         else if ($urandom_range(0, 99) < 30)
            pop_stall = pick_gap();
      end
   end

   // ---------------------------------------------------------------
   // Monitor: rising edge, predict on accepted requests, check popped tokens
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         lex_mode  = MODE_IDLE;
         kw_state  = KW_NONE;
         byte_pos  = '0;
         run_start = '0;
         run_len   = '0;
         run_ovf   = 1'b0;
      end else begin
         req_taken <= push && !full;
         if (push && !full)
            lex_byte(req_data);
         if (pop && !empty) begin
            if (tokens_due.size() == 0) begin
               $display("%0t: unexpected token, expected none, actual %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = tokens_due.pop_front();
               check_field("token_kind", want.token_kind, rsp_data.token_kind);
               check_field("start_offset", want.start_offset, rsp_data.start_offset);
               check_field("lexeme_length", want.lexeme_length, rsp_data.lexeme_length);
               check_field("length_saturated", want.length_saturated,
                           rsp_data.length_saturated);
               check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------
   initial begin : stimulus
      int unsigned base;
      bit          drained;

      // Directed: every token kind, run ends on symbols, flush on letters
      add_text("var=const;");
      end_source();
      add_text("_x9+");
      end_source();
      add_byte(8'hFF);
      add_byte(8'h80);
      add_byte("b");
      end_source();
      add_text("12a");
      end_source();

      // Long runs: exactly at the length maximum, closed by a symbol, then one past it
      repeat (255) add_byte("a", 1'b1);
      add_byte(CH_SEMI);
      repeat (256) add_byte("z", 1'b1);
      end_source();
      add_drain();

      // Random part, with one full drain halfway
      base = source_text.size();
      drained = 1'b0;
      while (source_text.size() - base < RANDOM_BYTES) begin
         add_random_source();
         if (!drained && source_text.size() - base > RANDOM_BYTES / 2) begin
            add_drain();
            drained = 1'b1;
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (source_text.size() != 0 || push)
         @(posedge clock);
      while (tokens_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && tokens_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #30_000_000;
      $display("%0t: timeout, %0d tokens still expected", $time, tokens_due.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
